### hdl/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg: shared types and constants for the array linked list engine
// Operation and status codes, microcode control word and datapath flag groups.
// ----------------------------------------------------------------------------
package alle_pkg;

    localparam int DEF_SLOT_COUNT = 64;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int CAP_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // a listing never returns more than this many values
    localparam logic [CAP_W-1:0] LIST_LIMIT = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PREPEND = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_LIST    = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // datapath operation selected by the current microinstruction
    typedef enum logic [2:0] {
        UOP_FETCH     = 3'd0,
        UOP_PP_CHECK  = 3'd1,
        UOP_PP_LINK   = 3'd2,
        UOP_RM_START  = 3'd3,
        UOP_RM_STEP   = 3'd4,
        UOP_RM_UNLINK = 3'd5,
        UOP_LS_START  = 3'd6,
        UOP_LS_STEP   = 3'd7
    } t_uop;

    typedef enum logic [1:0] {
        BR_A    = 2'd0,
        BR_B    = 2'd1,
        BR_ELSE = 2'd2
    } t_br;

    typedef enum logic [2:0] {
        C_NONE       = 3'd0,
        C_TRUE       = 3'd1,
        C_FREE_NULL  = 3'd2,
        C_HEAD_NULL  = 3'd3,
        C_LIST_EMPTY = 3'd4,
        C_MATCH      = 3'd5,
        C_WALK_END   = 3'd6,
        C_LIST_END   = 3'd7
    } t_cond;

    typedef logic [2:0] t_upc;

    typedef struct packed {
        logic    en;
        t_status status;
        logic    last;
    } t_emit;

    typedef struct packed {
        t_uop  op;
        logic  dispatch;
        logic  emit_data;
        t_cond cond_a;
        t_upc  tgt_a;
        t_emit emit_a;
        t_cond cond_b;
        t_upc  tgt_b;
        t_emit emit_b;
        t_upc  tgt_e;
        t_emit emit_e;
    } t_ctrl;

    typedef struct packed {
        logic free_null;
        logic head_null;
        logic list_empty;
        logic match;
        logic walk_end;
        logic list_end;
    } t_flags;

    typedef struct packed {
        logic  fire;
        t_uop  op;
        t_br   br;
        t_emit emit;
        logic  emit_data;
    } t_uctl;

endpackage

### hdl/array_linked_list_engine.sv
// Steps: prepend runs fetch, check, link; remove fetch, start, a step per node visited,
// unlink on a hit; listing fetch, start, a step per value. A full prepend ends at check,
// an empty remove or listing at start. Throughput: one operation at a time, the next
// accepted once its last result is issued; a walk visits one node per cycle, set by the
// single read port of the link memory, a listing walk only while the output has room.
// Reset is synchronous; slots at or above the fill mark read as chained.
// ----------------------------------------------------------------------------
// array_linked_list_engine: array backed linked list with free list
// Microcoded sequencer driving a node pool datapath, with a registered output
// stage on the result stream.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
    parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value[31:0], max_items[38:32], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // data_value[31:0], entry_count[38:32], zero pad
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    output logic        o_m_axis_tlast    // last
);

    alle_pkg::t_flags w_flags;
    alle_pkg::t_uctl  w_uctl;
    logic             w_out_room;
    logic [alle_pkg::VALUE_W-1:0] w_data;
    logic [alle_pkg::COUNT_W-1:0] w_count;

    logic                          r_out_valid;
    alle_pkg::t_status             r_out_status;
    logic [alle_pkg::VALUE_W-1:0]  r_out_data;
    logic [alle_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_last;

    assign w_out_room = !r_out_valid || i_m_axis_tready;

    alle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_flags    (w_flags),
        .i_out_room (w_out_room),
        .o_in_ready (o_s_axis_tready),
        .o_uctl     (w_uctl)
    );

    alle_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uctl      (w_uctl),
        .i_value     (i_s_axis_tdata[31:0]),
        .i_max_items (i_s_axis_tdata[38:32]),
        .o_flags     (w_flags),
        .o_data      (w_data),
        .o_count     (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uctl.fire && w_uctl.emit.en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uctl.fire && w_uctl.emit.en) begin
            r_out_status <= w_uctl.emit.status;
            r_out_data   <= w_uctl.emit_data ? w_data : '0;
            r_out_count  <= w_count;
            r_out_last   <= w_uctl.emit.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_data};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

endmodule

### hdl/alle_seq.sv
// ----------------------------------------------------------------------------
// alle_seq: microcode sequencer
// Step counter, control store and branch selection. A step fires unless it
// waits for an input transaction or its result finds the output stage full.
// ----------------------------------------------------------------------------
module alle_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [alle_pkg::KIND_W-1:0] i_kind,
    input  alle_pkg::t_flags            i_flags,
    input  logic                        i_out_room,
    output logic                        o_in_ready,
    output alle_pkg::t_uctl             o_uctl
);

    localparam alle_pkg::t_upc PC_FETCH = 3'd0;
    localparam alle_pkg::t_upc PC_PP0   = 3'd1;
    localparam alle_pkg::t_upc PC_PP1   = 3'd2;
    localparam alle_pkg::t_upc PC_RM0   = 3'd3;
    localparam alle_pkg::t_upc PC_RM1   = 3'd4;
    localparam alle_pkg::t_upc PC_RM2   = 3'd5;
    localparam alle_pkg::t_upc PC_LS0   = 3'd6;
    localparam alle_pkg::t_upc PC_LS1   = 3'd7;

    localparam alle_pkg::t_emit E_NONE = '{en: 1'b0, status: alle_pkg::ST_OK, last: 1'b0};
    localparam alle_pkg::t_emit E_OK   = '{en: 1'b1, status: alle_pkg::ST_OK, last: 1'b1};
    localparam alle_pkg::t_emit E_MORE = '{en: 1'b1, status: alle_pkg::ST_OK, last: 1'b0};
    localparam alle_pkg::t_emit E_FULL = '{en: 1'b1, status: alle_pkg::ST_FULL, last: 1'b1};
    localparam alle_pkg::t_emit E_MISS = '{en: 1'b1, status: alle_pkg::ST_NOT_FOUND,
                                           last: 1'b1};
    localparam alle_pkg::t_emit E_EMPTY = '{en: 1'b1, status: alle_pkg::ST_EMPTY, last: 1'b1};

    // control store
    function automatic alle_pkg::t_ctrl rom_word(input alle_pkg::t_upc pc);
        alle_pkg::t_ctrl w;
        w = '{op: alle_pkg::UOP_FETCH, dispatch: 1'b1, emit_data: 1'b0,
              cond_a: alle_pkg::C_NONE, tgt_a: PC_FETCH, emit_a: E_NONE,
              cond_b: alle_pkg::C_NONE, tgt_b: PC_FETCH, emit_b: E_NONE,
              tgt_e: PC_FETCH, emit_e: E_NONE};
        case (pc)
            PC_PP0: begin
                w.op = alle_pkg::UOP_PP_CHECK; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_FREE_NULL; w.emit_a = E_FULL;
                w.tgt_e = PC_PP1;
            end
            PC_PP1: begin
                w.op = alle_pkg::UOP_PP_LINK; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_TRUE; w.emit_a = E_OK;
            end
            PC_RM0: begin
                w.op = alle_pkg::UOP_RM_START; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_HEAD_NULL; w.emit_a = E_MISS;
                w.tgt_e = PC_RM1;
            end
            PC_RM1: begin
                w.op = alle_pkg::UOP_RM_STEP; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_MATCH; w.tgt_a = PC_RM2;
                w.cond_b = alle_pkg::C_WALK_END; w.emit_b = E_MISS;
                w.tgt_e = PC_RM1;
            end
            PC_RM2: begin
                w.op = alle_pkg::UOP_RM_UNLINK; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_TRUE; w.emit_a = E_OK;
            end
            PC_LS0: begin
                w.op = alle_pkg::UOP_LS_START; w.dispatch = 1'b0;
                w.cond_a = alle_pkg::C_LIST_EMPTY; w.emit_a = E_EMPTY;
                w.tgt_e = PC_LS1;
            end
            PC_LS1: begin
                w.op = alle_pkg::UOP_LS_STEP; w.dispatch = 1'b0; w.emit_data = 1'b1;
                w.cond_a = alle_pkg::C_LIST_END; w.emit_a = E_OK;
                w.tgt_e = PC_LS1; w.emit_e = E_MORE;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic cond_hit(input alle_pkg::t_cond c, input alle_pkg::t_flags f);
        logic h;
        case (c)
            alle_pkg::C_TRUE:       h = 1'b1;
            alle_pkg::C_FREE_NULL:  h = f.free_null;
            alle_pkg::C_HEAD_NULL:  h = f.head_null;
            alle_pkg::C_LIST_EMPTY: h = f.list_empty;
            alle_pkg::C_MATCH:      h = f.match;
            alle_pkg::C_WALK_END:   h = f.walk_end;
            alle_pkg::C_LIST_END:   h = f.list_end;
            default:                h = 1'b0;
        endcase
        return h;
    endfunction

    alle_pkg::t_upc  r_upc;
    alle_pkg::t_upc  n_upc;
    alle_pkg::t_ctrl w_ctrl;
    alle_pkg::t_br   w_br;
    alle_pkg::t_emit w_emit;
    alle_pkg::t_upc  w_tgt;
    alle_pkg::t_upc  w_disp;
    logic            w_fire;

    always_comb begin
        w_ctrl = rom_word(r_upc);
        if (cond_hit(w_ctrl.cond_a, i_flags)) begin
            w_br = alle_pkg::BR_A; w_emit = w_ctrl.emit_a; w_tgt = w_ctrl.tgt_a;
        end else if (cond_hit(w_ctrl.cond_b, i_flags)) begin
            w_br = alle_pkg::BR_B; w_emit = w_ctrl.emit_b; w_tgt = w_ctrl.tgt_b;
        end else begin
            w_br = alle_pkg::BR_ELSE; w_emit = w_ctrl.emit_e; w_tgt = w_ctrl.tgt_e;
        end

        case (i_kind)
            alle_pkg::KIND_PREPEND: w_disp = PC_PP0;
            alle_pkg::KIND_REMOVE:  w_disp = PC_RM0;
            alle_pkg::KIND_LIST:    w_disp = PC_LS0;
            default:                w_disp = PC_FETCH;  // unused kind: dropped
        endcase

        w_fire = w_ctrl.dispatch ? i_in_valid : !(w_emit.en && !i_out_room);

        n_upc = r_upc;
        if (w_fire) begin
            n_upc = w_ctrl.dispatch ? w_disp : w_tgt;
        end
    end

    assign o_in_ready        = w_ctrl.dispatch;
    assign o_uctl.fire       = w_fire;
    assign o_uctl.op         = w_ctrl.op;
    assign o_uctl.br         = w_br;
    assign o_uctl.emit       = w_emit;
    assign o_uctl.emit_data  = w_ctrl.emit_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= PC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

### hdl/alle_dpath.sv
// ----------------------------------------------------------------------------
// alle_dpath: node pool datapath
// Value and link memories, head pointers, element count and walk registers.
// Slots at or above the fill mark were never allocated and link to slot+1.
// ----------------------------------------------------------------------------
module alle_dpath #(
    parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  alle_pkg::t_uctl               i_uctl,
    input  logic [alle_pkg::VALUE_W-1:0]  i_value,
    input  logic [alle_pkg::CAP_W-1:0]    i_max_items,
    output alle_pkg::t_flags              o_flags,
    output logic [alle_pkg::VALUE_W-1:0]  o_data,
    output logic [alle_pkg::COUNT_W-1:0]  o_count
);

    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOT_COUNT);

    logic [alle_pkg::VALUE_W-1:0] r_values [SLOT_COUNT];
    logic [LW-1:0]                r_links  [SLOT_COUNT];

    logic [LW-1:0] r_list_head, n_list_head;
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_count,     n_count;
    logic [LW-1:0] r_fill,      n_fill;
    logic [LW-1:0] r_cur,       n_cur;
    logic [LW-1:0] r_prev,      n_prev;
    logic [LW-1:0] r_steps,     n_steps;
    logic [alle_pkg::CAP_W-1:0]   r_left, n_left;
    logic [alle_pkg::CAP_W-1:0]   r_cap,  n_cap;
    logic [alle_pkg::VALUE_W-1:0] r_val,  n_val;

    logic [alle_pkg::VALUE_W-1:0] r_value_q;
    logic [LW-1:0]                r_link_q;
    logic [SW-1:0]                r_raddr_q;

    logic [LW-1:0] w_raddr_ext;
    logic [LW-1:0] w_link_eff;
    logic [LW-1:0] w_steps_next;
    logic          w_rd_en;
    logic [SW-1:0] w_rd_addr;
    logic          w_val_we;
    logic [SW-1:0] w_val_waddr;
    logic          w_link_we;
    logic [SW-1:0] w_link_waddr;
    logic [LW-1:0] w_link_wdata;

    assign w_raddr_ext  = LW'(r_raddr_q);
    assign w_link_eff   = (w_raddr_ext >= r_fill) ? LW'(w_raddr_ext + 1'b1) : r_link_q;
    assign w_steps_next = LW'(r_steps + 1'b1);

    assign o_flags.free_null  = (r_free_head >= NULL_LINK);
    assign o_flags.head_null  = (r_list_head >= NULL_LINK);
    assign o_flags.list_empty = (r_list_head >= NULL_LINK) || (r_cap == '0);
    assign o_flags.match      = (r_value_q == r_val);
    assign o_flags.walk_end   = (w_link_eff >= NULL_LINK) || (w_steps_next >= NULL_LINK);
    assign o_flags.list_end   = (w_link_eff >= NULL_LINK) || (w_steps_next >= NULL_LINK)
                                || (r_left == alle_pkg::CAP_W'(1));

    assign o_data  = r_value_q;
    assign o_count = alle_pkg::COUNT_W'(n_count);

    always_comb begin
        n_list_head  = r_list_head;
        n_free_head  = r_free_head;
        n_count      = r_count;
        n_fill       = r_fill;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_left       = r_left;
        n_cap        = r_cap;
        n_val        = r_val;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_list_head[SW-1:0];
        w_val_we     = 1'b0;
        w_val_waddr  = r_free_head[SW-1:0];
        w_link_we    = 1'b0;
        w_link_waddr = r_free_head[SW-1:0];
        w_link_wdata = r_list_head;

        if (i_uctl.fire) begin
            case (i_uctl.op)
                alle_pkg::UOP_FETCH: begin
                    n_val = i_value;
                    n_cap = (i_max_items > alle_pkg::LIST_LIMIT) ? alle_pkg::LIST_LIMIT
                                                                 : i_max_items;
                end
                alle_pkg::UOP_PP_CHECK: begin
                    if (i_uctl.br == alle_pkg::BR_ELSE) begin
                        w_val_we  = 1'b1;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_free_head[SW-1:0];
                    end
                end
                alle_pkg::UOP_PP_LINK: begin
                    w_link_we   = 1'b1;
                    n_list_head = r_free_head;
                    n_free_head = w_link_eff;
                    n_count     = LW'(r_count + 1'b1);
                    if (r_free_head == r_fill) begin
                        n_fill = LW'(r_fill + 1'b1);
                    end
                end
                alle_pkg::UOP_RM_START: begin
                    if (i_uctl.br == alle_pkg::BR_ELSE) begin
                        n_cur     = r_list_head;
                        n_prev    = NULL_LINK;
                        n_steps   = '0;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_list_head[SW-1:0];
                    end
                end
                alle_pkg::UOP_RM_STEP: begin
                    if (i_uctl.br == alle_pkg::BR_A) begin
                        // bypass the matching node
                        if (r_prev >= NULL_LINK) begin
                            n_list_head = w_link_eff;
                        end else begin
                            w_link_we    = 1'b1;
                            w_link_waddr = r_prev[SW-1:0];
                            w_link_wdata = w_link_eff;
                        end
                    end else begin
                        n_prev  = r_cur;
                        n_cur   = w_link_eff;
                        n_steps = w_steps_next;
                        if (i_uctl.br == alle_pkg::BR_ELSE) begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_link_eff[SW-1:0];
                        end
                    end
                end
                alle_pkg::UOP_RM_UNLINK: begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_cur[SW-1:0];
                    w_link_wdata = r_free_head;
                    n_free_head  = r_cur;
                    if (r_count != '0) begin
                        n_count = LW'(r_count - 1'b1);
                    end
                end
                alle_pkg::UOP_LS_START: begin
                    if (i_uctl.br == alle_pkg::BR_ELSE) begin
                        n_left    = r_cap;
                        n_steps   = '0;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_list_head[SW-1:0];
                    end
                end
                alle_pkg::UOP_LS_STEP: begin
                    if (i_uctl.br == alle_pkg::BR_ELSE) begin
                        n_left    = alle_pkg::CAP_W'(r_left - 1'b1);
                        n_steps   = w_steps_next;
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_link_eff[SW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_values[w_val_waddr] <= r_val;
        end
        if (w_rd_en) begin
            r_value_q <= r_values[w_rd_addr];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_links[w_link_waddr] <= w_link_wdata;
        end
        if (w_rd_en) begin
            r_link_q  <= r_links[w_rd_addr];
            r_raddr_q <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= NULL_LINK;
            r_free_head <= '0;
            r_count     <= '0;
            r_fill      <= '0;
        end else begin
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_left  <= n_left;
        r_cap   <= n_cap;
        r_val   <= n_val;
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the array linked list engine
// Sends prepend, remove and listing transactions, predicts every result from
// an own copy of the node pool and free list, and checks each result field by
// field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS = alle_pkg::DEF_SLOT_COUNT;
    localparam logic [alle_pkg::CAP_W-1:0] NULL_LINK = alle_pkg::CAP_W'(SLOTS);
    localparam logic [alle_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int MAX_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AT = 70;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [alle_pkg::KIND_W-1:0]  kind;
        logic [alle_pkg::VALUE_W-1:0] value;
        logic [alle_pkg::CAP_W-1:0]   cap;
    } t_list_op;

    typedef struct packed {
        alle_pkg::t_status            status;
        logic [alle_pkg::VALUE_W-1:0] data;
        logic [alle_pkg::COUNT_W-1:0] count;
        logic                         last;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;
    logic [1:0]  s_kind = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // stimulus and predicted results
    t_list_op                     op_queue[$];
    logic [alle_pkg::VALUE_W-1:0] value_pool[$];
    t_list_result                 awaited_results[$];

    // predicted node pool
    logic [alle_pkg::VALUE_W-1:0] node_value[SLOTS];
    logic [alle_pkg::CAP_W-1:0]   node_next[SLOTS];
    logic [alle_pkg::CAP_W-1:0]   head_idx;
    logic [alle_pkg::CAP_W-1:0]   free_idx;
    logic [alle_pkg::COUNT_W-1:0] node_total;

    int  mismatch_count = 0;
    int  accepted_ops = 0;
    int  cycle_count = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    logic rx_hold = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    array_linked_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------

    task automatic clear_pool();
        for (int i = 0; i < SLOTS; i++) begin
            node_value[i] = '0;
            node_next[i]  = alle_pkg::CAP_W'(i + 1);
        end
        head_idx   = NULL_LINK;
        free_idx   = '0;
        node_total = '0;
    endtask

    task automatic push_result(input alle_pkg::t_status st,
                               input logic [alle_pkg::VALUE_W-1:0] d, input logic l);
        t_list_result r;
        r.status = st;
        r.data   = d;
        r.count  = node_total;
        r.last   = l;
        awaited_results.push_back(r);
    endtask

    task automatic apply_list_op(input logic [alle_pkg::KIND_W-1:0] kind,
                                 input logic [alle_pkg::VALUE_W-1:0] value,
                                 input logic [alle_pkg::CAP_W-1:0] cap);
        logic [alle_pkg::CAP_W-1:0] cur;
        logic [alle_pkg::CAP_W-1:0] prev;
        logic [alle_pkg::CAP_W-1:0] lim;
        int steps;
        int emitted;
        bit found;
        case (kind)
            alle_pkg::KIND_PREPEND: begin
                if (free_idx >= SLOTS) begin
                    push_result(alle_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    cur = free_idx;
                    free_idx = node_next[cur];
                    node_value[cur] = value;
                    node_next[cur] = head_idx;
                    head_idx = cur;
                    node_total = node_total + 1'b1;
                    push_result(alle_pkg::ST_OK, '0, 1'b1);
                end
            end
            alle_pkg::KIND_REMOVE: begin
                prev  = NULL_LINK;
                cur   = head_idx;
                steps = 0;
                found = 1'b0;
                while (!found && cur < SLOTS && steps < SLOTS) begin
                    if (node_value[cur] == value) begin
                        found = 1'b1;
                        if (prev >= SLOTS)
                            head_idx = node_next[cur];
                        else
                            node_next[prev] = node_next[cur];
                        node_next[cur] = free_idx;
                        free_idx = cur;
                        if (node_total != 0)
                            node_total = node_total - 1'b1;
                    end else begin
                        prev = cur;
                        cur  = node_next[cur];
                        steps++;
                    end
                end
                push_result(found ? alle_pkg::ST_OK : alle_pkg::ST_NOT_FOUND, '0, 1'b1);
            end
            alle_pkg::KIND_LIST: begin
                lim = (cap > alle_pkg::LIST_LIMIT) ? alle_pkg::LIST_LIMIT : cap;
                cur = head_idx;
                emitted = 0;
                // lim never exceeds the slot count, so it also bounds the walk
                while (cur < SLOTS && emitted < lim) begin
                    push_result(alle_pkg::ST_OK, node_value[cur],
                                node_next[cur] >= SLOTS || emitted + 1 == lim);
                    emitted++;
                    cur = node_next[cur];
                end
                if (emitted == 0)
                    push_result(alle_pkg::ST_EMPTY, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    // ---------------- stimulus ----------------

    task automatic add_op(input logic [alle_pkg::KIND_W-1:0] kind,
                          input logic [alle_pkg::VALUE_W-1:0] value,
                          input logic [alle_pkg::CAP_W-1:0] cap);
        t_list_op op;
        op.kind  = kind;
        op.value = value;
        op.cap   = cap;
        op_queue.push_back(op);
        if (kind == alle_pkg::KIND_PREPEND)
            value_pool.push_back(value);
    endtask

    function automatic logic [alle_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            // narrow range so duplicates show up in the list
            4, 5, 6: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [alle_pkg::VALUE_W-1:0] pick_target();
        if (value_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [alle_pkg::CAP_W-1:0] pick_cap();
        case ($urandom_range(0, 7))
            0: return 7'd127;
            1: return 7'd0;
            2: return alle_pkg::LIST_LIMIT;
            3: return alle_pkg::CAP_W'($urandom);
            default: return alle_pkg::CAP_W'($urandom_range(1, 20));
        endcase
    endfunction

    task automatic add_random(input int n, input int pp_pct, input int rm_pct,
                              input int ls_pct);
        int roll;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < pp_pct)
                add_op(alle_pkg::KIND_PREPEND, pick_value(), alle_pkg::CAP_W'($urandom));
            else if (roll < pp_pct + rm_pct)
                add_op(alle_pkg::KIND_REMOVE, pick_target(), alle_pkg::CAP_W'($urandom));
            else if (roll < pp_pct + rm_pct + ls_pct)
                add_op(alle_pkg::KIND_LIST, $urandom, pick_cap());
            else
                add_op(KIND_IGNORED, $urandom, alle_pkg::CAP_W'($urandom));
        end
    endtask

    task automatic build_stimulus();
        // empty list cases
        add_op(alle_pkg::KIND_LIST,   '0, alle_pkg::LIST_LIMIT);
        add_op(alle_pkg::KIND_REMOVE, 32'd5, '0);
        add_op(KIND_IGNORED, '0, '0);
        // field extremes, with a duplicate of all ones
        add_op(alle_pkg::KIND_PREPEND, 32'h8000_0000, '0);
        add_op(alle_pkg::KIND_PREPEND, 32'h7fff_ffff, 7'd127);
        add_op(alle_pkg::KIND_PREPEND, '0, '0);
        add_op(alle_pkg::KIND_PREPEND, 32'hffff_ffff, '0);
        add_op(alle_pkg::KIND_PREPEND, 32'hffff_ffff, '0);
        // zero limit, saturated limit, short limit
        add_op(alle_pkg::KIND_LIST, '1, 7'd0);
        add_op(alle_pkg::KIND_LIST, '0, 7'd127);
        add_op(alle_pkg::KIND_LIST, '0, 7'd2);
        // head, middle, tail and a miss
        add_op(alle_pkg::KIND_REMOVE, 32'hffff_ffff, '0);
        add_op(alle_pkg::KIND_REMOVE, 32'h7fff_ffff, '0);
        add_op(alle_pkg::KIND_REMOVE, 32'h8000_0000, '0);
        add_op(alle_pkg::KIND_REMOVE, 32'd12345, '0);
        add_op(alle_pkg::KIND_LIST,   '0, alle_pkg::LIST_LIMIT);
        add_op(KIND_IGNORED, '1, '1);
        add_op(alle_pkg::KIND_REMOVE, 32'hffff_ffff, '0);
        add_op(alle_pkg::KIND_REMOVE, '0, '0);
        add_op(alle_pkg::KIND_LIST,   '0, 7'd1);
        add_op(alle_pkg::KIND_PREPEND, 32'd1, '0);
        add_op(alle_pkg::KIND_LIST,   '0, 7'd1);
        // random part: mixed, then fill past full, then drain by removes
        add_random(30, 50, 25, 20);
        add_random(70, 95, 0, 5);
        add_op(alle_pkg::KIND_LIST, '0, 7'd127);
        add_random(47, 10, 65, 20);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else if (!s_valid || o_s_axis_tready) begin
            if (s_valid) begin
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 14);
            end
            if (send_wait == 0 && op_queue.size() != 0) begin
                t_list_op op;
                op = op_queue.pop_front();
                s_valid <= 1'b1;
                s_data  <= {1'b0, op.cap, op.value};
                s_kind  <= op.kind;
            end else begin
                s_valid <= 1'b0;
                if (send_wait != 0)
                    send_wait--;
            end
        end
    end

    // ---------------- monitor and checker ----------------

    task automatic check_field(input string field,
                               input logic [alle_pkg::VALUE_W-1:0] exp_v,
                               input logic [alle_pkg::VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("result %s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            recv_wait = 0;
            clear_pool();
        end else begin
            // outputs first, so a result can never match an item accepted this edge
            if (o_m_axis_tvalid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: status %0d data 0x%0h count %0d",
                                 o_m_axis_tuser, o_m_axis_tdata[31:0],
                                 o_m_axis_tdata[38:32]);
                end else begin
                    t_list_result r;
                    r = awaited_results.pop_front();
                    check_field("status", alle_pkg::VALUE_W'(r.status),
                                alle_pkg::VALUE_W'(o_m_axis_tuser));
                    check_field("data_value", r.data, o_m_axis_tdata[31:0]);
                    check_field("entry_count", alle_pkg::VALUE_W'(r.count),
                                alle_pkg::VALUE_W'(o_m_axis_tdata[38:32]));
                    check_field("last", alle_pkg::VALUE_W'(r.last),
                                alle_pkg::VALUE_W'(o_m_axis_tlast));
                end
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
            end
            if (s_valid && o_s_axis_tready) begin
                apply_list_op(s_kind, s_data[31:0], s_data[38:32]);
                accepted_ops <= accepted_ops + 1;
            end
            if (recv_wait != 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_hold;
            end
        end
    end

    // long receiver stall while the list fills, to back up the input side
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rx_hold   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                rx_hold <= 1'b0;
        end else if (!hold_done && accepted_ops == HOLD_AT) begin
            rx_hold   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        while (op_queue.size() != 0 || s_valid)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hdl/alle_pkg.sv
hdl/alle_seq.sv
hdl/alle_dpath.sv
hdl/array_linked_list_engine.sv
tb/sv/tb_top.sv
